// ===== sv/trnl_pkg.sv =====
// Package for the timestamped ring lookup block: word types, opcodes,
// controller states and the command/status bundles between the two halves.
// No dependencies.
package trnl_pkg;

    // Default ring depth.
    localparam int CAPACITY_DEFAULT = 64;

    // Operation codes carried in the opcode field of an input word.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_NEAREST = 2'd1,
        OP_LATEST  = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    // Input word.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [63:0] time_stamp;
        logic               entry_valid;
        logic [63:0]        pose_data;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic               found;
        logic signed [63:0] result_stamp;
        logic [63:0]        result_data;
    } out_word_t;

    // One stored ring entry.
    typedef struct packed {
        logic [63:0] stamp;
        logic        valid;
        logic [63:0] payload;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_wr;
        logic start_lookup;
        logic scan_rd;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
    } status_t;

endpackage

// ===== sv/trnl_dp.sv =====
// Datapath of the timestamped ring lookup: entry memory, write pointer,
// fill count, scan address walk, distance pipeline and result register.
// Depends on trnl_pkg.
module trnl_dp #(
    parameter int CAPACITY = trnl_pkg::CAPACITY_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  trnl_pkg::cmd_t      cmd,
    input  trnl_pkg::in_word_t  in_word,
    output trnl_pkg::status_t   status,
    output trnl_pkg::out_word_t out_word
);
    import trnl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry memory: one write port (push), one registered read port (scan).
    entry_t mem [CAPACITY];

    logic [AW-1:0]      wp_reg, wp_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      left_reg, left_next;
    logic               q_nearest_reg;
    logic [63:0]        q_stamp_reg;

    entry_t             rd_data_reg;
    logic               s1_vld_reg;

    logic [63:0]        stamp_dist;
    logic [63:0]        d_reg;
    logic [63:0]        s2_stamp_reg;
    logic [63:0]        s2_payload_reg;
    logic               s2_vld_reg;

    logic               have_reg;
    logic [63:0]        best_dist_reg;
    logic [63:0]        best_stamp_reg;
    logic [63:0]        best_payload_reg;
    logic               take;

    out_word_t          out_reg;

    // Pointer and count updates; the read pointer walks from newest to oldest.
    always_comb begin
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        left_next   = left_reg;
        if (cmd.push_wr) begin
            wp_next = (wp_reg == AW'(CAPACITY - 1)) ? '0 : wp_reg + AW'(1);
            if (cnt_reg != CW'(CAPACITY)) begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        if (cmd.start_lookup) begin
            rd_ptr_next = (wp_reg == '0) ? AW'(CAPACITY - 1) : wp_reg - AW'(1);
            left_next   = cnt_reg;
        end else if (cmd.scan_rd) begin
            rd_ptr_next = (rd_ptr_reg == '0) ? AW'(CAPACITY - 1) : rd_ptr_reg - AW'(1);
            left_next   = left_reg - CW'(1);
        end
    end

    // Control registers of the datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            cnt_reg    <= '0;
            rd_ptr_reg <= '0;
            left_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            have_reg   <= 1'b0;
        end else begin
            wp_reg     <= wp_next;
            cnt_reg    <= cnt_next;
            rd_ptr_reg <= rd_ptr_next;
            left_reg   <= left_next;
            s1_vld_reg <= cmd.scan_rd;
            s2_vld_reg <= s1_vld_reg & rd_data_reg.valid;
            if (cmd.start_lookup) begin
                have_reg <= 1'b0;
            end else if (take) begin
                have_reg <= 1'b1;
            end
        end
    end

    // Memory write on push and registered read during the scan.
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[wp_reg] <= '{stamp:   in_word.time_stamp,
                             valid:   in_word.entry_valid,
                             payload: in_word.pose_data};
        end
        if (cmd.scan_rd) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Query capture.
    always_ff @(posedge aclk) begin
        if (cmd.start_lookup) begin
            q_nearest_reg <= (in_word.opcode == OP_NEAREST);
            q_stamp_reg   <= in_word.time_stamp;
        end
    end

    // Exact unsigned distance between the entry stamp and the query stamp.
    always_comb begin
        if ($signed(rd_data_reg.stamp) >= $signed(q_stamp_reg)) begin
            stamp_dist = rd_data_reg.stamp - q_stamp_reg;
        end else begin
            stamp_dist = q_stamp_reg - rd_data_reg.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg          <= stamp_dist;
        s2_stamp_reg   <= rd_data_reg.stamp;
        s2_payload_reg <= rd_data_reg.payload;
    end

    // Keep the best candidate; a strict compare lets the newer entry win a tie.
    assign take = s2_vld_reg && (!have_reg || (q_nearest_reg && (d_reg < best_dist_reg)));

    always_ff @(posedge aclk) begin
        if (take) begin
            best_dist_reg    <= d_reg;
            best_stamp_reg   <= s2_stamp_reg;
            best_payload_reg <= s2_payload_reg;
        end
    end

    // Result register; zero fields when nothing was found.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.found        <= have_reg;
            out_reg.result_stamp <= have_reg ? best_stamp_reg : '0;
            out_reg.result_data  <= have_reg ? best_payload_reg : '0;
        end
    end

    assign out_word          = out_reg;
    assign status.count_zero = (cnt_reg == '0);
    assign status.scan_last  = (left_reg == CW'(1));
    assign status.pipe_busy  = s1_vld_reg | s2_vld_reg;

endmodule

// ===== sv/trnl_ctrl.sv =====
// Controller of the timestamped ring lookup: accepts words, sequences the
// scan and drain, and owns the result valid flag. Depends on trnl_pkg.
module trnl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        opcode,
    output logic              m_valid,
    input  logic              m_ready,
    input  trnl_pkg::status_t status,
    output trnl_pkg::cmd_t    cmd
);
    import trnl_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (opcode == OP_NEAREST || opcode == OP_LATEST)) begin
                    state_next = status.count_zero ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready          = 1'b1;
                cmd.push_wr      = accept && (opcode == OP_PUSH);
                cmd.start_lookup = accept && (opcode == OP_NEAREST || opcode == OP_LATEST);
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
                cmd.load_out = !status.pipe_busy && out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/timestamped_ring_nearest_lookup.sv =====
// Top level of the timestamped ring lookup: controller plus datapath.
// Depends on trnl_pkg, trnl_ctrl and trnl_dp.
//
//  Channel | Ports                       | Direction | Carries
//  --------+-----------------------------+-----------+---------------------------
//  input   | s_valid, s_ready, s_data    | in        | push or lookup word
//  result  | m_valid, m_ready, m_data    | out       | one word per lookup
//
// A push gives no result. A lookup scans the written entries, at most
// CAPACITY of them, from newest to oldest: the scan reads one entry per cycle
// through the single memory read port, then two pipeline stages drain and
// the result register loads.
// Reset (aresetn low, synchronous) clears pointer, count and control state;
// entries are only read once written, so the memory needs no clearing.
// The result register frees the input side; a lookup that finishes while an
// earlier result still waits holds until that result is taken.
module timestamped_ring_nearest_lookup #(
    parameter int CAPACITY = trnl_pkg::CAPACITY_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trnl_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trnl_pkg::out_word_t m_data
);
    import trnl_pkg::*;

    cmd_t    cmd;
    status_t status;

    trnl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    trnl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_word  (s_data),
        .status   (status),
        .out_word (m_data)
    );

endmodule

// ===== sv/trnl_chk.sv =====
// Port-level checker for the timestamped ring lookup, with its bind.
// Depends on trnl_pkg and timestamped_ring_nearest_lookup.
module trnl_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input trnl_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input trnl_pkg::out_word_t m_data
);
    import trnl_pkg::*;

    // A result word that waits holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // An accepted lookup busies the input side for at least the next cycle.
    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_NEAREST || s_data.opcode == OP_LATEST)
        |=> !s_ready)
        else $error("input ready right after a lookup");

    // A push never blocks the next word.
    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.opcode == OP_PUSH |=> s_ready)
        else $error("input ready dropped after a push");

    // A miss returns zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.result_stamp == '0 && m_data.result_data == '0)
        else $error("miss carries nonzero fields");

    // Out of reset the block is idle with no pending result.
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind timestamped_ring_nearest_lookup trnl_chk u_trnl_chk (.*);
